>>> design/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// No dependencies; used by first_fit_block_allocator and its testbench.
package ffba_pkg;

  // Default number of block table entries
  localparam int DEF_TABLE_ENTRIES = 32;

  // Configuration register layout
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_TYPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_USED_TYPE = 1'b1;
  localparam logic [3:0] FREE_TYPE_RESET = 4'd1;
  localparam logic [3:0] USED_TYPE_RESET = 4'd6;

  // Commands
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_SIZE  = 2'd3
  } cmd_t;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMATCH = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] request_addr;
    logic [31:0] request_size;
    logic [3:0]  region_type;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_addr;
    logic [31:0] result_size;
    logic [1:0]  status;
  } out_item_t;

endpackage

>>> design/first_fit_block_allocator.sv
// First-fit block allocator: linked block table in one RAM, walked by a sequencer.
// Depends on ffba_pkg and ffba_ram.
//
//   channel | ports                          | transfer when
//   --------+--------------------------------+------------------------------
//   input   | start, busy, in_item           | start high and busy low
//   result  | out_valid, out_item            | out_valid high (one cycle)
//   config  | cfg_wr_en, cfg_index, cfg_wdata | cfg_wr_en high
//
// Add region completes without a walk. Allocate, free and get size walk the list
// one table entry per cycle through the RAM read port, visiting n blocks
// (n <= TABLE_ENTRIES); a split adds the S_SPLIT state for its
// second RAM write. The result appears in the cycle after completion.
// Synchronous active-low reset empties the list; table contents are not cleared.
// The receiver cannot stall; busy holds off new commands during a walk or split.
module first_fit_block_allocator
  #(
  parameter int TABLE_ENTRIES = ffba_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  ffba_pkg::in_item_t                in_item,
  output logic                              out_valid,
  output ffba_pkg::out_item_t               out_item,
  input  logic                              cfg_wr_en,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ffba_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import ffba_pkg::*;

  localparam int LINK_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W = $clog2(TABLE_ENTRIES);
  localparam int WORD_W = 32 + 32 + 4 + LINK_W;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(TABLE_ENTRIES);
  localparam logic [LINK_W-1:0] LAST_IDX  = LINK_W'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_SPLIT = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [3:0]        free_code_r, used_code_r;
  logic [LINK_W-1:0] list_start_r, list_start_nxt;
  logic [LINK_W-1:0] eiu_r, eiu_nxt;
  logic [LINK_W-1:0] steps_r, steps_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic [31:0]       size_r, size_nxt;
  logic [31:0]       base_r, base_nxt;
  logic [31:0]       diff_r, diff_nxt;
  logic [LINK_W-1:0] link_r, link_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  // Index of the entry whose data sits on the read port
  logic [LINK_W-1:0] cur_r, cur_nxt;

  // RAM signals
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;

  // Fields of the entry under inspection
  logic [31:0]       e_base, e_len;
  logic [3:0]        e_kind;
  logic [LINK_W-1:0] e_link;
  logic [32:0]       len_diff;
  logic [31:0]       split_base;

  assign {e_base, e_len, e_kind, e_link} = rd_data;

  // Two adders: length minus request during the walk, base plus
  // difference during the split
  assign len_diff   = {1'b0, e_len} - {1'b0, size_r};
  assign split_base = base_r + diff_r;

  ffba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Follow the link while walking, else point at the list head
  assign rd_addr = (state_r == S_WALK) ? e_link[ADDR_W-1:0] : list_start_r[ADDR_W-1:0];

  // Sequencer
  always_comb begin
    logic done;
    done           = 1'b0;
    state_nxt      = state_r;
    list_start_nxt = list_start_r;
    eiu_nxt        = eiu_r;
    steps_nxt      = steps_r;
    cmd_nxt        = cmd_r;
    addr_nxt       = addr_r;
    size_nxt       = size_r;
    base_nxt       = base_r;
    diff_nxt       = diff_r;
    link_nxt       = link_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = '0;
    wr_en          = 1'b0;
    wr_addr        = eiu_r[ADDR_W-1:0];
    wr_data        = rd_data;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt  = in_item.command;
          addr_nxt = in_item.request_addr;
          size_nxt = in_item.request_size;
          steps_nxt = '0;
          if (in_item.command == CMD_ADD) begin
            out_valid_nxt = 1'b1;
            if (eiu_r >= NULL_LINK) begin
              out_nxt.status = ST_FULL;
            end else begin
              // Push the new region at the list head
              wr_en          = 1'b1;
              wr_data        = {in_item.request_addr, in_item.request_size,
                                in_item.region_type, list_start_r};
              list_start_nxt = eiu_r;
              eiu_nxt        = eiu_r + 1'b1;
              out_nxt.status = ST_OK;
            end
          end else if (list_start_r >= NULL_LINK) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = ST_NOMATCH;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        case (cmd_r)
          CMD_ALLOC: begin
            if (e_kind == free_code_r && !len_diff[32]) begin
              done          = 1'b1;
              out_valid_nxt = 1'b1;
              if (e_len == size_r) begin
                // Exact fit: retype in place
                wr_en              = 1'b1;
                wr_addr            = cur_r[ADDR_W-1:0];
                wr_data            = {e_base, e_len, used_code_r, e_link};
                out_nxt.result_addr = e_base;
                out_nxt.status     = ST_OK;
              end else if (eiu_r < LAST_IDX) begin
                // Shrink this block and link the new entry after it
                wr_en         = 1'b1;
                wr_addr       = cur_r[ADDR_W-1:0];
                wr_data       = {e_base, len_diff[31:0], e_kind, eiu_r};
                base_nxt      = e_base;
                diff_nxt      = len_diff[31:0];
                link_nxt      = e_link;
                out_valid_nxt = 1'b0;
                state_nxt     = S_SPLIT;
              end else begin
                out_nxt.status = ST_FULL;
              end
            end
          end
          CMD_FREE: begin
            if (e_base == addr_r) begin
              done           = 1'b1;
              out_valid_nxt  = 1'b1;
              wr_en          = 1'b1;
              wr_addr        = cur_r[ADDR_W-1:0];
              wr_data        = {e_base, e_len, free_code_r, e_link};
              out_nxt.status = ST_OK;
            end
          end
          CMD_SIZE: begin
            if (e_base == addr_r) begin
              done                = 1'b1;
              out_valid_nxt       = 1'b1;
              out_nxt.result_size = e_len;
              out_nxt.status      = ST_OK;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (!done) begin
          if (steps_r == LAST_IDX || e_link >= NULL_LINK) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = ST_NOMATCH;
            state_nxt      = S_IDLE;
          end else begin
            steps_nxt = steps_r + 1'b1;
          end
        end else if (state_nxt == S_WALK) begin
          state_nxt = S_IDLE;
        end
      end
      S_SPLIT: begin
        // Write the new used entry at the top end of the split block
        wr_en               = 1'b1;
        wr_data             = {split_base, size_r, used_code_r, link_r};
        eiu_nxt             = eiu_r + 1'b1;
        out_valid_nxt       = 1'b1;
        out_nxt.result_addr = split_base;
        out_nxt.status      = ST_OK;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Track the entry being read: head on entry to the walk, then each link
  always_comb begin
    cur_nxt = cur_r;
    if (state_r == S_IDLE) begin
      cur_nxt = list_start_r;
    end else if (state_r == S_WALK) begin
      cur_nxt = e_link;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      list_start_r <= NULL_LINK;
      eiu_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      list_start_r <= list_start_nxt;
      eiu_r        <= eiu_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_code_r <= FREE_TYPE_RESET;
      used_code_r <= USED_TYPE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FREE_TYPE: free_code_r <= cfg_wdata;
        CFG_USED_TYPE: used_code_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    steps_r <= steps_nxt;
    cmd_r   <= cmd_nxt;
    addr_r  <= addr_nxt;
    size_r  <= size_nxt;
    base_r  <= base_nxt;
    diff_r  <= diff_nxt;
    link_r  <= link_nxt;
    cur_r   <= cur_nxt;
    if (out_valid_nxt) begin
      out_r <= out_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // A result only follows a transfer, the end of a walk or a split
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(start && !busy) || $past(state_r != S_IDLE)))
    else $error("result without a command");

  // The fill count never passes the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    eiu_r <= NULL_LINK)
    else $error("fill count beyond table size");

  // A split always leaves the last entry in reserve
  a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPLIT) |-> (eiu_r < LAST_IDX))
    else $error("split without room");

  // A split returns to idle with a successful result in the cycle after
  a_split_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPLIT) |=> (state_r == S_IDLE && out_valid_r && out_r.status == ST_OK))
    else $error("split did not complete");

endmodule

>>> design/ffba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> tb/first_fit_block_allocator_tb.sv
// Self-checking testbench for first_fit_block_allocator: directed table, then random phases.
// Depends on ffba_pkg and the design; keeps its own copy of the block table to predict results.
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam int TABLE_ENTRIES = DEF_TABLE_ENTRIES;
  localparam int NULL_IDX = TABLE_ENTRIES;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int TAIL_CYCLES = 2 * TABLE_ENTRIES + 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int REPORT_MAX = 10;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow of the block table and its settings
  logic [31:0] tbl_base [TABLE_ENTRIES];
  logic [31:0] tbl_len  [TABLE_ENTRIES];
  logic [3:0]  tbl_kind [TABLE_ENTRIES];
  int          tbl_next [TABLE_ENTRIES];
  int          head_idx;
  int          n_entries;
  logic [3:0]  free_code;
  logic [3:0]  used_code;

  out_item_t   pending_outcomes[$];
  out_item_t   want_item;
  int unsigned fail_count;
  int unsigned cycle_count;
  dir_row_t    dir_rows[22];

  first_fit_block_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one command to the shadow table and return the result it gives
  function automatic out_item_t allocator_outcome(in_item_t it);
    out_item_t r;
    int        cur;
    int        steps;
    int        e;
    bit        done;
    r = '0;
    r.status = ST_OK;
    if (it.command == CMD_ADD) begin
      if (n_entries >= TABLE_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        e = n_entries;
        tbl_base[e] = it.request_addr;
        tbl_len[e]  = it.request_size;
        tbl_kind[e] = it.region_type;
        tbl_next[e] = head_idx;
        head_idx    = e;
        n_entries   = e + 1;
      end
    end else if (it.command == CMD_ALLOC) begin
      // first fit: exact match is retyped, a larger block gives up its top end
      r.status = ST_NOMATCH;
      cur = head_idx;
      done = 1'b0;
      for (steps = 0; steps < TABLE_ENTRIES && cur < NULL_IDX && !done; steps++) begin
        if (tbl_kind[cur] == free_code && tbl_len[cur] == it.request_size) begin
          tbl_kind[cur] = used_code;
          r.result_addr = tbl_base[cur];
          r.status = ST_OK;
          done = 1'b1;
        end else if (tbl_kind[cur] == free_code && tbl_len[cur] > it.request_size) begin
          if (n_entries < TABLE_ENTRIES - 1) begin
            e = n_entries;
            tbl_base[e]   = tbl_base[cur] + tbl_len[cur] - it.request_size;
            tbl_len[e]    = it.request_size;
            tbl_kind[e]   = used_code;
            tbl_next[e]   = tbl_next[cur];
            tbl_len[cur]  = tbl_len[cur] - it.request_size;
            tbl_next[cur] = e;
            n_entries     = e + 1;
            r.result_addr = tbl_base[e];
            r.status = ST_OK;
          end else begin
            r.status = ST_FULL;
          end
          done = 1'b1;
        end else begin
          cur = tbl_next[cur];
        end
      end
    end else begin
      // free and get size act on the first block with a matching base
      cur = head_idx;
      done = 1'b0;
      for (steps = 0; steps < TABLE_ENTRIES && cur < NULL_IDX && !done; steps++) begin
        if (tbl_base[cur] == it.request_addr) done = 1'b1;
        else cur = tbl_next[cur];
      end
      if (!done) begin
        r.status = ST_NOMATCH;
      end else if (it.command == CMD_FREE) begin
        tbl_kind[cur] = free_code;
      end else begin
        r.result_size = tbl_len[cur];
      end
    end
    return r;
  endfunction

  function automatic dir_row_t mk_row(cmd_t c, logic [31:0] a, logic [31:0] s, logic [3:0] t,
                                      bit typed, logic [31:0] ea, logic [31:0] es,
                                      logic [1:0] est);
    dir_row_t row;
    row.item.command      = c;
    row.item.request_addr = a;
    row.item.request_size = s;
    row.item.region_type  = t;
    row.typed             = typed;
    row.want.result_addr  = ea;
    row.want.result_size  = es;
    row.want.status       = est;
    return row;
  endfunction

  function automatic logic [31:0] known_base();
    return tbl_base[$urandom_range(0, n_entries - 1)];
  endfunction

  // Mostly well-formed requests aimed at blocks already in the table
  function automatic in_item_t pick_request();
    in_item_t it;
    int       roll;
    int       e;
    it.request_addr = $urandom;
    it.request_size = $urandom;
    it.region_type  = 4'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < ((n_entries < TABLE_ENTRIES) ? 18 : 3)) begin
      it.command = CMD_ADD;
      roll = $urandom_range(0, 9);
      if (roll < 7) it.request_size = $urandom_range(1, 32'h1000);
      else if (roll == 7) it.request_size = '0;
      roll = $urandom_range(0, 9);
      if (roll < 6) it.region_type = free_code;
      else if (roll < 8) it.region_type = used_code;
    end else if (roll < 55) begin
      it.command = CMD_ALLOC;
      roll = $urandom_range(0, 9);
      if (n_entries > 0 && roll < 7) begin
        e = $urandom_range(0, n_entries - 1);
        if (roll < 4) it.request_size = tbl_len[e];
        else it.request_size = $urandom_range(0, tbl_len[e]);
      end else if (roll < 9) begin
        it.request_size = $urandom_range(0, 32'h200);
      end
    end else begin
      it.command = (roll < 82) ? CMD_FREE : CMD_SIZE;
      if (n_entries > 0 && $urandom_range(0, 3) != 0) it.request_addr = known_base();
    end
    return it;
  endfunction

  // Present one transfer and hold it until the block takes it
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t r;
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = allocator_outcome(it);
    pending_outcomes.push_back(typed ? want : r);
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Drop start and wait until every outstanding result has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_outcomes.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [3:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_FREE_TYPE) free_code = val;
    else used_code = val;
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result: addr %h size %h status %0d",
                   out_item.result_addr, out_item.result_size, out_item.status);
      end else begin
        want_item = pending_outcomes.pop_front();
        if (out_item.result_addr !== want_item.result_addr ||
            out_item.result_size !== want_item.result_size ||
            out_item.status !== want_item.status) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("mismatch: addr %h/%h size %h/%h status %0d/%0d (expected/actual)",
                     want_item.result_addr, out_item.result_addr,
                     want_item.result_size, out_item.result_size,
                     want_item.status, out_item.status);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("first_fit_block_allocator regression: fail");
      $finish;
    end
  end

  initial begin
    int        burst_left;
    int        gap_max;
    int        phase;
    int        k;
    logic [3:0] fc;
    logic [3:0] uc;
    out_item_t  none;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    fail_count  = 0;
    cycle_count = 0;
    head_idx    = NULL_IDX;
    n_entries   = 0;
    free_code   = FREE_TYPE_RESET;
    used_code   = USED_TYPE_RESET;
    none        = '0;
    for (k = 0; k < TABLE_ENTRIES; k++) begin
      tbl_base[k] = '0;
      tbl_len[k]  = '0;
      tbl_kind[k] = '0;
      tbl_next[k] = 0;
    end

    // Empty list, zero sizes, wrap on split, exact fits, double free, misses
    dir_rows = '{
      mk_row(CMD_SIZE,  32'h0000_0000, 32'h0000_0000, 4'h0, 1, '0, '0, ST_NOMATCH),
      mk_row(CMD_FREE,  32'h0000_0000, 32'hFFFF_FFFF, 4'hF, 1, '0, '0, ST_NOMATCH),
      mk_row(CMD_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000, 4'h0, 1, '0, '0, ST_NOMATCH),
      mk_row(CMD_ADD,   32'h0000_1000, 32'h0000_0100, 4'h1, 1, '0, '0, ST_OK),
      mk_row(CMD_ADD,   32'hFFFF_FFF0, 32'h0000_0020, 4'h1, 1, '0, '0, ST_OK),
      mk_row(CMD_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1, '0, '0, ST_OK),
      mk_row(CMD_ADD,   32'h0000_2000, 32'h0000_0000, 4'h1, 1, '0, '0, ST_OK),
      mk_row(CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 4'h0, 1, 32'h0000_2000, '0, ST_OK),
      mk_row(CMD_ALLOC, 32'h0000_0000, 32'h0000_0008, 4'h0, 0, '0, '0, ST_OK),
      mk_row(CMD_SIZE,  32'hFFFF_FFF0, 32'h0000_0000, 4'h0, 0, '0, '0, ST_OK),
      mk_row(CMD_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF, 4'hF, 1, '0, '0, ST_NOMATCH),
      mk_row(CMD_FREE,  32'h0000_2000, 32'h0000_0000, 4'h0, 1, '0, '0, ST_OK),
      mk_row(CMD_FREE,  32'h0000_2000, 32'h0000_0000, 4'h0, 1, '0, '0, ST_OK),
      mk_row(CMD_SIZE,  32'h0000_2000, 32'hFFFF_FFFF, 4'hF, 1, '0, '0, ST_OK),
      mk_row(CMD_ALLOC, 32'h0000_0000, 32'h0000_0100, 4'h0, 0, '0, '0, ST_OK),
      mk_row(CMD_ALLOC, 32'h0000_0000, 32'h0000_0001, 4'h0, 0, '0, '0, ST_OK),
      mk_row(CMD_SIZE,  32'hFFFF_FFFF, 32'h0000_0000, 4'h0, 0, '0, '0, ST_OK),
      mk_row(CMD_FREE,  32'h1234_5678, 32'h0000_0000, 4'h0, 1, '0, '0, ST_NOMATCH),
      mk_row(CMD_ADD,   32'h0000_0000, 32'h0000_0000, 4'h0, 0, '0, '0, ST_OK),
      mk_row(CMD_FREE,  32'hFFFF_FFFF, 32'h0000_0000, 4'h0, 0, '0, '0, ST_OK),
      mk_row(CMD_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF, 4'h0, 0, '0, '0, ST_OK),
      mk_row(CMD_SIZE,  32'h0000_0008, 32'h0000_0000, 4'h0, 0, '0, '0, ST_OK)
    };

    // Hold reset, release on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table with reset register values, random gaps between rows
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 5));
    end

    // Random phases, each with its own type codes; extremes first, reset values last
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin fc = 4'h0; uc = 4'hF; end
        1: begin fc = 4'hF; uc = 4'h0; end
        2: begin fc = 4'h3; uc = 4'h3; end
        5: begin fc = FREE_TYPE_RESET; uc = USED_TYPE_RESET; end
        default: begin fc = 4'($urandom); uc = 4'($urandom); end
      endcase
      drain();
      write_register(CFG_FREE_TYPE, fc);
      write_register(CFG_USED_TYPE, uc);
      gap_max = (phase == 2) ? 0 : $urandom_range(2, 10);
      burst_left = 0;
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (gap_max > 0 && $urandom_range(0, 3) != 0) hold_off($urandom_range(1, gap_max));
        end
        send_item(pick_request(), 1'b0, none);
        burst_left--;
      end
    end

    // Wait out the last results, then a short tail for stray ones
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_outcomes.size() == 0) begin
      $display("first_fit_block_allocator regression: pass");
    end else begin
      $display("first_fit_block_allocator regression: fail");
    end
    $finish;
  end

endmodule
